FILE: design/box_blur_3x3_edge_clipped_unit_assert.svh
// ----------------------------------------------------------------------------
// Box blur assertion macros
// Concurrent assertion shorthands shared by the box blur RTL. Define
// ASSERT_OFF to compile them away.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_EDGE_CLIPPED_UNIT_ASSERT_SVH
`define BOX_BLUR_3X3_EDGE_CLIPPED_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define BB3_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bb3 assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BB3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bb3 assertion failed");

`else

`define BB3_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define BB3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/bb3_pkg.sv
// ----------------------------------------------------------------------------
// Box blur package
// Sizes, register indexes, codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package bb3_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 4096;
    localparam int HIST_DEPTH   = 2 * MAX_WIDTH + 2;
    localparam int ADDR_W       = $clog2(HIST_DEPTH);
    localparam int OFF_W        = ADDR_W + 1;
    localparam int IDX_W        = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int WEFF_W       = $clog2(MAX_WIDTH + 1);
    localparam int HEFF_W       = $clog2(MAX_HEIGHT + 1);

    localparam int WFIELD_W     = 11;
    localparam int HFIELD_W     = 13;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 13;

    localparam int CH_W         = 8;
    localparam int NUM_CH       = 4;
    localparam int PIX_W        = CH_W * NUM_CH;
    localparam int SUM_W        = $clog2(9 * 255 + 1);
    localparam int CNT_W        = $clog2(10);
    localparam int STEP_W       = $clog2(SUM_W);

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = CFG_ADDR_W'(1);

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    // neighbour row / column relative to the output pixel
    localparam logic [1:0] TAP_PREV = 2'd0;
    localparam logic [1:0] TAP_CUR  = 2'd1;
    localparam logic [1:0] TAP_NEXT = 2'd2;

    typedef struct packed {
        logic       store;      // write pixel, advance input position
        logic       set_drain;  // flush seen
        logic       restart;    // flush with nothing left: back to frame start
        logic       acc_clear;  // clear sums and count
        logic       tap_issue;  // read one neighbour
        logic [1:0] tap_row;
        logic [1:0] tap_col;
        logic       advance;    // advance output position, decide frame end
        logic       div_step;   // one restoring divide step on all channels
        logic       out_load;   // load result into output register
    } t_cmd;

    typedef struct packed {
        logic pix_ok;       // a pixel would be stored
        logic pix_emit;     // a stored pixel releases a result
        logic flush_empty;  // nothing left to drain
        logic out_free;     // output register can take a result
    } t_status;

endpackage

FILE: design/bb3_ctrl.sv
// ----------------------------------------------------------------------------
// Box blur controller
// Sequences accept, neighbour reads, divide and output load for one item.
// ----------------------------------------------------------------------------
module bb3_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    input  logic            i_s_tuser,
    output logic            o_s_tready,
    input  bb3_pkg::t_status i_status,
    output bb3_pkg::t_cmd   o_cmd
);
    import bb3_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_GATHER = 3'd1;
    localparam logic [2:0] S_ACC    = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [1:0]        r_row, n_row;
    logic [1:0]        r_col, n_col;
    logic [STEP_W-1:0] r_step, n_step;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.tap_row = r_row;
        o_cmd.tap_col = r_col;
        unique case (r_state)
            S_IDLE: begin
                n_row = TAP_PREV;
                n_col = TAP_PREV;
                if (i_s_tvalid) begin
                    if (i_s_tuser == REQ_FLUSH) begin
                        if (i_status.flush_empty) begin
                            o_cmd.restart = 1'b1;
                        end else begin
                            o_cmd.set_drain = 1'b1;
                            o_cmd.acc_clear = 1'b1;
                            n_state         = S_GATHER;
                        end
                    end else if (i_status.pix_ok) begin
                        o_cmd.store = 1'b1;
                        if (i_status.pix_emit) begin
                            o_cmd.acc_clear = 1'b1;
                            n_state         = S_GATHER;
                        end
                    end
                end
            end
            S_GATHER: begin
                o_cmd.tap_issue = 1'b1;
                if (r_col == TAP_NEXT) begin
                    n_col = TAP_PREV;
                    n_row = r_row + 2'd1;
                    if (r_row == TAP_NEXT) begin
                        n_state = S_ACC;
                    end
                end else begin
                    n_col = r_col + 2'd1;
                end
            end
            S_ACC: begin
                o_cmd.advance = 1'b1;
                n_step        = '0;
                n_state       = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + STEP_W'(1);
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= TAP_PREV;
            r_col   <= TAP_PREV;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_step  <= n_step;
        end
    end

endmodule

FILE: design/bb3_datapath.sv
// ----------------------------------------------------------------------------
// Box blur datapath
// Line store, frame positions, neighbour accumulation, divider and output reg.
// ----------------------------------------------------------------------------
`include "box_blur_3x3_edge_clipped_unit_assert.svh"

module bb3_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bb3_pkg::t_cmd                     i_cmd,
    output bb3_pkg::t_status                  o_status,
    input  logic [bb3_pkg::PIX_W-1:0]         i_s_tdata,
    input  logic                              i_cfg_we,
    input  logic [bb3_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [bb3_pkg::PIX_W-1:0]         o_m_tdata,
    output logic                              o_m_tlast
);
    import bb3_pkg::*;

    // frame geometry (already clipped to the legal range)
    logic [WEFF_W-1:0] r_w_eff;
    logic [HEFF_W-1:0] r_h_eff;

    // input and output positions
    logic [IDX_W-1:0]  r_in_idx, r_out_idx;
    logic [ADDR_W-1:0] r_wptr, r_optr;
    logic [WEFF_W-1:0] r_in_x, r_ox;
    logic [HEFF_W-1:0] r_in_y, r_oy;
    logic              r_draining;

    // line store
    logic [PIX_W-1:0]  mem [HIST_DEPTH];
    logic [PIX_W-1:0]  r_rd_data;
    logic              r_tap_vld;

    // accumulate / divide
    logic [SUM_W-1:0]  r_sum [NUM_CH];
    logic [CNT_W-1:0]  r_rem [NUM_CH];
    logic [CNT_W-1:0]  r_cnt;
    logic              r_fend;

    // output register
    logic              r_out_valid;
    logic [PIX_W-1:0]  r_out_data;
    logic              r_out_last;

    logic [WFIELD_W-1:0] cfg_w_raw;
    logic [HFIELD_W-1:0] cfg_h_raw;
    logic [WEFF_W-1:0]   cfg_w_eff;
    logic [HEFF_W-1:0]   cfg_h_eff;
    logic                cfg_restart;

    logic signed [OFF_W-1:0] w_s, row_off, col_off, off;
    logic                    row_ok, col_ok, arrived, tap_ok;
    logic signed [IDX_W:0]   nb_idx;
    logic [OFF_W:0]          a_sum;
    logic [ADDR_W-1:0]       rd_addr;

    logic [IDX_W-1:0]  out_idx_nxt;
    logic              frame_end;
    logic              restart_all;
    logic [CNT_W-1:0]  divisor;

    // ---------------------------------------------------------------- config
    assign cfg_w_raw = i_cfg_data[WFIELD_W-1:0];
    assign cfg_h_raw = i_cfg_data[HFIELD_W-1:0];

    always_comb begin
        if (cfg_w_raw == '0) begin
            cfg_w_eff = WEFF_W'(1);
        end else if (cfg_w_raw > MAX_WIDTH) begin
            cfg_w_eff = WEFF_W'(MAX_WIDTH);
        end else begin
            cfg_w_eff = WEFF_W'(cfg_w_raw);
        end
        if (cfg_h_raw == '0) begin
            cfg_h_eff = HEFF_W'(1);
        end else if (cfg_h_raw > MAX_HEIGHT) begin
            cfg_h_eff = HEFF_W'(MAX_HEIGHT);
        end else begin
            cfg_h_eff = HEFF_W'(cfg_h_raw);
        end
    end

    assign cfg_restart = i_cfg_we &&
                         ((i_cfg_addr == REG_IMAGE_WIDTH) || (i_cfg_addr == REG_IMAGE_HEIGHT));

    // ---------------------------------------------------------------- status
    assign o_status.pix_ok      = !r_draining && (r_in_y < r_h_eff);
    assign o_status.pix_emit    = r_in_idx > IDX_W'(r_w_eff);
    assign o_status.flush_empty = r_out_idx >= r_in_idx;
    assign o_status.out_free    = !r_out_valid || i_m_tready;

    // ------------------------------------------------------- neighbour decode
    assign w_s = signed'(OFF_W'(r_w_eff));

    always_comb begin
        unique case (i_cmd.tap_row)
            TAP_PREV: begin
                row_off = -w_s;
                row_ok  = (r_oy != '0);
            end
            TAP_CUR: begin
                row_off = '0;
                row_ok  = 1'b1;
            end
            TAP_NEXT: begin
                row_off = w_s;
                row_ok  = ((HEFF_W + 1)'(r_oy) + 1'b1) < (HEFF_W + 1)'(r_h_eff);
            end
            default: begin
                row_off = '0;
                row_ok  = 1'b0;
            end
        endcase
        unique case (i_cmd.tap_col)
            TAP_PREV: begin
                col_off = -OFF_W'(1);
                col_ok  = (r_ox != '0);
            end
            TAP_CUR: begin
                col_off = '0;
                col_ok  = 1'b1;
            end
            TAP_NEXT: begin
                col_off = OFF_W'(1);
                col_ok  = ((WEFF_W + 1)'(r_ox) + 1'b1) < (WEFF_W + 1)'(r_w_eff);
            end
            default: begin
                col_off = '0;
                col_ok  = 1'b0;
            end
        endcase
    end

    assign off = row_off + col_off;

    // skip neighbours that have not arrived yet
    assign nb_idx  = signed'({1'b0, r_out_idx}) +
                     signed'({{(IDX_W + 1 - OFF_W){off[OFF_W-1]}}, off});
    assign arrived = nb_idx < signed'({1'b0, r_in_idx});
    assign tap_ok  = row_ok && col_ok && arrived;

    // wrap the read address into the ring once in either direction
    assign a_sum = {2'b00, r_optr} + {off[OFF_W-1], off};

    always_comb begin
        if (a_sum[OFF_W]) begin
            rd_addr = ADDR_W'(a_sum + (OFF_W + 1)'(HIST_DEPTH));
        end else if (a_sum >= (OFF_W + 1)'(HIST_DEPTH)) begin
            rd_addr = ADDR_W'(a_sum - (OFF_W + 1)'(HIST_DEPTH));
        end else begin
            rd_addr = ADDR_W'(a_sum);
        end
    end

    // ------------------------------------------------------------ line store
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            mem[r_wptr] <= i_s_tdata;
        end
        if (i_cmd.tap_issue) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // ------------------------------------------------------------- positions
    assign out_idx_nxt = r_out_idx + IDX_W'(1);
    assign frame_end   = r_draining && (out_idx_nxt >= r_in_idx);
    assign restart_all = cfg_restart || i_cmd.restart || (i_cmd.advance && frame_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_eff     <= WEFF_W'(RESET_WIDTH);
            r_h_eff     <= HEFF_W'(RESET_HEIGHT);
            r_in_idx    <= '0;
            r_out_idx   <= '0;
            r_wptr      <= '0;
            r_optr      <= '0;
            r_in_x      <= '0;
            r_in_y      <= '0;
            r_ox        <= '0;
            r_oy        <= '0;
            r_draining  <= 1'b0;
            r_tap_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_addr == REG_IMAGE_WIDTH)) begin
                r_w_eff <= cfg_w_eff;
            end
            if (i_cfg_we && (i_cfg_addr == REG_IMAGE_HEIGHT)) begin
                r_h_eff <= cfg_h_eff;
            end

            if (restart_all) begin
                r_in_idx   <= '0;
                r_out_idx  <= '0;
                r_wptr     <= '0;
                r_optr     <= '0;
                r_in_x     <= '0;
                r_in_y     <= '0;
                r_ox       <= '0;
                r_oy       <= '0;
                r_draining <= 1'b0;
            end else begin
                if (i_cmd.store) begin
                    r_in_idx <= r_in_idx + IDX_W'(1);
                    r_wptr   <= (r_wptr == ADDR_W'(HIST_DEPTH - 1)) ? '0
                                                                     : r_wptr + ADDR_W'(1);
                    if (r_in_x == r_w_eff - WEFF_W'(1)) begin
                        r_in_x <= '0;
                        r_in_y <= r_in_y + HEFF_W'(1);
                    end else begin
                        r_in_x <= r_in_x + WEFF_W'(1);
                    end
                end
                if (i_cmd.set_drain) begin
                    r_draining <= 1'b1;
                end
                if (i_cmd.advance) begin
                    r_out_idx <= out_idx_nxt;
                    r_optr    <= (r_optr == ADDR_W'(HIST_DEPTH - 1)) ? '0
                                                                     : r_optr + ADDR_W'(1);
                    if (r_ox == r_w_eff - WEFF_W'(1)) begin
                        r_ox <= '0;
                        r_oy <= r_oy + HEFF_W'(1);
                    end else begin
                        r_ox <= r_ox + WEFF_W'(1);
                    end
                end
            end

            r_tap_vld <= i_cmd.tap_issue && tap_ok;

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ----------------------------------------------------- accumulate, divide
    assign divisor = (r_cnt == '0) ? CNT_W'(1) : r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clear) begin
            r_cnt <= '0;
            for (int c = 0; c < NUM_CH; c++) begin
                r_sum[c] <= '0;
                r_rem[c] <= '0;
            end
        end else if (r_tap_vld) begin
            r_cnt <= r_cnt + CNT_W'(1);
            for (int c = 0; c < NUM_CH; c++) begin
                r_sum[c] <= r_sum[c] + SUM_W'(r_rd_data[c*CH_W +: CH_W]);
            end
        end else if (i_cmd.div_step) begin
            // restoring step: the sum register shifts out dividend, in quotient
            for (int c = 0; c < NUM_CH; c++) begin
                if ({r_rem[c], r_sum[c][SUM_W-1]} >= {1'b0, divisor}) begin
                    r_rem[c] <= CNT_W'({r_rem[c], r_sum[c][SUM_W-1]} - {1'b0, divisor});
                    r_sum[c] <= {r_sum[c][SUM_W-2:0], 1'b1};
                end else begin
                    r_rem[c] <= CNT_W'({r_rem[c], r_sum[c][SUM_W-1]});
                    r_sum[c] <= {r_sum[c][SUM_W-2:0], 1'b0};
                end
            end
        end
        if (i_cmd.advance) begin
            r_fend <= frame_end;
        end
        if (i_cmd.out_load) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_out_data[c*CH_W +: CH_W] <= r_sum[c][CH_W-1:0];
            end
            r_out_last <= r_fend;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    // ------------------------------------------------------------ assertions
    `BB3_ASSERT_IMPLY(a_out_behind_in, i_clk, i_rst_n, 1'b1, r_out_idx <= r_in_idx)
    `BB3_ASSERT_IMPLY(a_advance_pending, i_clk, i_rst_n, i_cmd.advance, r_out_idx < r_in_idx)
    `BB3_ASSERT_IMPLY(a_center_counted, i_clk, i_rst_n, i_cmd.out_load, r_cnt != '0)
    `BB3_ASSERT_NEXT(a_frame_end_restarts, i_clk, i_rst_n, i_cmd.advance && frame_end, (r_in_idx == '0) && !r_draining)

endmodule

FILE: design/box_blur_3x3_edge_clipped_unit.sv
// ----------------------------------------------------------------------------
// 3x3 box blur, edge clipped
// Streaming RGBA blur: each output pixel is the floor mean of its in-frame
// 3x3 neighbourhood, trailing the input by one row plus one pixel.
// ----------------------------------------------------------------------------
// Send one frame of RGBA pixels in raster order (tuser low), then flush beats
// (tuser high) to drain the remaining width+1 results; the result that drains
// the last received pixel carries tlast and the block is then ready for the
// next frame. Neighbours outside the frame, or not yet received when a frame
// is cut short by a flush, are left out of the mean. A beat that releases no
// result (a pixel of the first row plus one, an extra pixel, a flush with
// nothing left) is taken without leaving the idle state. A beat that releases
// a result holds off the next beat while it goes through the accept step, nine
// reads of the line store through its single read port, an accumulate step,
// twelve steps of the bit-serial divider, and the output register load. A result
// waiting in the output register does not hold off the next input beat; only
// a second result waits for it. The line store needs no clearing pass after
// reset. Write image_width (index 0) and image_height (index 1) only while
// the block is idle; either write abandons the frame in progress, and values
// out of range are clipped to 1..1024 and 1..4096.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_clipped_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [bb3_pkg::PIX_W-1:0]       i_s_tdata,  // red_in, green_in, blue_in, alpha_in
    input  logic                            i_s_tuser,  // req_type
    // result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [bb3_pkg::PIX_W-1:0]       o_m_tdata,  // red_out, green_out, blue_out, alpha_out
    output logic                            o_m_tlast,  // frame_end
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [bb3_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bb3_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequence each beat: accept, gather, divide, load result
    bb3_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // hold the line store, frame positions, sums and the output register
    bb3_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_s_tdata  (i_s_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
